// ===== design/gwbr_pkg.sv =====
`timescale 1ns / 1ps

package gwbr_pkg;

    localparam int WINDOW_DEPTH_DEF = 64;
    localparam int SAMPLE_BITS_DEF  = 16;

    // per-transaction control from the sequencer to each axis
    typedef struct packed {
        logic write;   // sample enters the ring and the running sum
        logic warmup;  // ring not yet full: nothing leaves the sum
        logic load;    // result register takes a new value
    } ctrl_t;

endpackage

// ===== design/gyro_window_bias_removal.sv =====
`timescale 1ns / 1ps

// Gyro bias removal over a moving window. Each axis keeps the last WINDOW_DEPTH
// samples in a ring memory and a running sum; the bias is the sum shifted right
// by log2(WINDOW_DEPTH), rounding toward minus infinity. The first WINDOW_DEPTH
// transactions after reset only fill the ring and produce no result; every later
// one produces rate minus bias, with the bias taken before this sample enters.
// After warm-up, a sample updates the window only when update_allowed is high.
// WINDOW_DEPTH must be a power of two. One transaction is accepted per cycle when
// the output is not stalled; a result enters the output register in the cycle
// after acceptance. The ring read is prefetched one position ahead, so the oldest
// entry is ready for the sum update. No clearing pass: warm-up fills the ring first.
module gyro_window_bias_removal #(
    parameter int WINDOW_DEPTH = gwbr_pkg::WINDOW_DEPTH_DEF,
    parameter int SAMPLE_BITS  = gwbr_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_rate_x_in,
    input  logic signed [SAMPLE_BITS-1:0] s_rate_y_in,
    input  logic signed [SAMPLE_BITS-1:0] s_rate_z_in,
    input  logic                          s_update_allowed,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS:0]   m_rate_x_out,
    output logic signed [SAMPLE_BITS:0]   m_rate_y_out,
    output logic signed [SAMPLE_BITS:0]   m_rate_z_out
);

    localparam int ADDR_W = $clog2(WINDOW_DEPTH);
    localparam int CNT_W  = ADDR_W + 1;

    gwbr_pkg::ctrl_t   ctrl;
    logic              accept;
    logic              warmup;
    logic [ADDR_W-1:0] pos_reg;
    logic [ADDR_W-1:0] pos_next;
    logic [CNT_W-1:0]  warm_cnt_reg;
    logic [CNT_W-1:0]  warm_cnt_next;
    logic              m_valid_reg;
    logic              m_valid_next;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign warmup  = warm_cnt_reg != CNT_W'(WINDOW_DEPTH);

    always_comb begin
        ctrl.write    = accept && (warmup || s_update_allowed);
        ctrl.warmup   = warmup;
        ctrl.load     = accept && !warmup;
        pos_next      = ctrl.write ? pos_reg + 1'b1 : pos_reg;
        warm_cnt_next = (accept && warmup) ? warm_cnt_reg + 1'b1 : warm_cnt_reg;
        if (ctrl.load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            warm_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            pos_reg      <= pos_next;
            warm_cnt_reg <= warm_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    gwbr_axis #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .ADDR_W       (ADDR_W)
    ) u_axis_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .wr_addr  (pos_reg),
        .rd_addr  (pos_next),
        .sample   (s_rate_x_in),
        .rate_out (m_rate_x_out)
    );

    gwbr_axis #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .ADDR_W       (ADDR_W)
    ) u_axis_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .wr_addr  (pos_reg),
        .rd_addr  (pos_next),
        .sample   (s_rate_y_in),
        .rate_out (m_rate_y_out)
    );

    gwbr_axis #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .ADDR_W       (ADDR_W)
    ) u_axis_z (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .wr_addr  (pos_reg),
        .rd_addr  (pos_next),
        .sample   (s_rate_z_in),
        .rate_out (m_rate_z_out)
    );

endmodule

// ===== design/gwbr_axis.sv =====
`timescale 1ns / 1ps

module gwbr_axis #(
    parameter int WINDOW_DEPTH = gwbr_pkg::WINDOW_DEPTH_DEF,
    parameter int SAMPLE_BITS  = gwbr_pkg::SAMPLE_BITS_DEF,
    parameter int ADDR_W       = $clog2(WINDOW_DEPTH)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  gwbr_pkg::ctrl_t               ctrl,
    input  logic [ADDR_W-1:0]             wr_addr,
    input  logic [ADDR_W-1:0]             rd_addr,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic signed [SAMPLE_BITS:0]   rate_out
);

    localparam int SUM_W = SAMPLE_BITS + ADDR_W;

    logic [SAMPLE_BITS-1:0]       window_mem [WINDOW_DEPTH];
    logic signed [SAMPLE_BITS-1:0] oldest_reg;
    logic signed [SUM_W-1:0]      sum_reg;
    logic signed [SUM_W-1:0]      sum_next;
    logic signed [SUM_W-1:0]      leaving;
    logic signed [SAMPLE_BITS-1:0] bias;
    logic signed [SAMPLE_BITS:0]  diff;
    logic signed [SAMPLE_BITS:0]  rate_out_reg;

    // the read port looks one step ahead, so the oldest entry is ready when needed
    always_ff @(posedge aclk) begin
        if (ctrl.write) begin
            window_mem[wr_addr] <= sample;
        end
        oldest_reg <= window_mem[rd_addr];
    end

    always_comb begin
        leaving  = ctrl.warmup ? '0 : SUM_W'(oldest_reg);
        sum_next = sum_reg + SUM_W'(sample) - leaving;
        // floor division by the depth is the top bits of the sum
        bias     = sum_reg[SUM_W-1:ADDR_W];
        diff     = (SAMPLE_BITS+1)'(sample) - (SAMPLE_BITS+1)'(bias);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else if (ctrl.write) begin
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            rate_out_reg <= diff;
        end
    end

    assign rate_out = rate_out_reg;

endmodule

// ===== design/gwbr_checker.sv =====
`timescale 1ns / 1ps

module gwbr_checker #(
    parameter int SAMPLE_BITS = gwbr_pkg::SAMPLE_BITS_DEF
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic signed [SAMPLE_BITS:0]   m_rate_x_out,
    input logic signed [SAMPLE_BITS:0]   m_rate_y_out,
    input logic signed [SAMPLE_BITS:0]   m_rate_z_out
);

    // a stalled result holds its value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_rate_x_out)
            && $stable(m_rate_y_out) && $stable(m_rate_z_out))
        else $error("result changed while stalled");

    // an empty output stage never blocks the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // a new result only follows an accepted transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready))
        else $error("result without a transaction");

    // a taken result with nothing accepted leaves the output empty
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !(s_valid && s_ready) |=> !m_valid)
        else $error("result repeated");

endmodule

bind gyro_window_bias_removal gwbr_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_gwbr_checker (.*);

// ===== bench/gyro_window_bias_removal_test.sv =====
`timescale 1ns / 1ps

typedef logic signed [gwbr_pkg::SAMPLE_BITS_DEF-1:0] sample_t;
typedef logic signed [gwbr_pkg::SAMPLE_BITS_DEF:0]   rate_t;

typedef struct packed {
    rate_t x;
    rate_t y;
    rate_t z;
} corrected_t;

class bias_scoreboard;
    localparam int DEPTH    = gwbr_pkg::WINDOW_DEPTH_DEF;
    localparam int SHIFT    = $clog2(DEPTH);
    localparam int SUM_BITS = gwbr_pkg::SAMPLE_BITS_DEF + SHIFT;

    sample_t                     ring [3][DEPTH];
    logic signed [SUM_BITS-1:0]  total [3];
    int unsigned                 slot;
    int unsigned                 filled;
    corrected_t                  expected_rates [$];
    int                          mismatches;

    function new();
        for (int a = 0; a < 3; a++) begin
            total[a] = '0;
        end
        slot       = 0;
        filled     = 0;
        mismatches = 0;
    endfunction

    function int pending();
        return expected_rates.size();
    endfunction

    // accepted input transaction: predict the corrected rates, then move the window
    function void take_sample(sample_t x, sample_t y, sample_t z, bit allow);
        sample_t    s [3];
        int         bias;
        int         diff [3];
        corrected_t r;
        s[0] = x;
        s[1] = y;
        s[2] = z;
        if (filled < DEPTH) begin
            // warm-up fills the ring regardless of update_allowed
            for (int a = 0; a < 3; a++) begin
                ring[a][slot] = s[a];
                total[a] += s[a];
            end
            slot = (slot + 1) % DEPTH;
            filled++;
            return;
        end
        for (int a = 0; a < 3; a++) begin
            bias    = int'(total[a] >>> SHIFT);
            diff[a] = int'(s[a]) - bias;
        end
        r.x = rate_t'(diff[0]);
        r.y = rate_t'(diff[1]);
        r.z = rate_t'(diff[2]);
        expected_rates.push_back(r);
        if (allow) begin
            for (int a = 0; a < 3; a++) begin
                total[a] += s[a] - ring[a][slot];
                ring[a][slot] = s[a];
            end
            slot = (slot + 1) % DEPTH;
        end
    endfunction

    function void check_output(rate_t x, rate_t y, rate_t z);
        corrected_t e;
        if (expected_rates.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result x=%0d y=%0d z=%0d", x, y, z);
            return;
        end
        e = expected_rates.pop_front();
        if (e.x !== x || e.y !== y || e.z !== z) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected x=%0d y=%0d z=%0d, got x=%0d y=%0d z=%0d",
                         e.x, e.y, e.z, x, y, z);
        end
    endfunction
endclass

module gyro_window_bias_removal_test;

    logic    aclk             = 1'b0;
    logic    aresetn          = 1'b0;
    logic    s_valid          = 1'b0;
    logic    s_ready;
    sample_t s_rate_x_in      = '0;
    sample_t s_rate_y_in      = '0;
    sample_t s_rate_z_in      = '0;
    logic    s_update_allowed = 1'b0;
    logic    m_valid;
    logic    m_ready          = 1'b0;
    rate_t   m_rate_x_out;
    rate_t   m_rate_y_out;
    rate_t   m_rate_z_out;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;

    bias_scoreboard sb;

    sample_t corners [5] = '{-16'sd32768, -16'sd1, 16'sd0, 16'sd1, 16'sd32767};

    gyro_window_bias_removal dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rate_x_in      (s_rate_x_in),
        .s_rate_y_in      (s_rate_y_in),
        .s_rate_z_in      (s_rate_z_in),
        .s_update_allowed (s_update_allowed),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_rate_x_out     (m_rate_x_out),
        .m_rate_y_out     (m_rate_y_out),
        .m_rate_z_out     (m_rate_z_out)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            sb.take_sample(s_rate_x_in, s_rate_y_in, s_rate_z_in, s_update_allowed);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_output(m_rate_x_out, m_rate_y_out, m_rate_z_out);
    end

    task automatic send_sample(input sample_t x, input sample_t y, input sample_t z,
                               input bit allow);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_rate_x_in      <= x;
        s_rate_y_in      <= y;
        s_rate_z_in      <= z;
        s_update_allowed <= allow;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // hold off the sender until every predicted result has come out
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // mostly a given offset with noise, sometimes corners or full range
    function automatic sample_t pick_rate(sample_t centre);
        int mode;
        mode = $urandom_range(9);
        if (mode == 0)
            return sample_t'($urandom);
        if (mode == 1)
            return corners[$urandom_range(4)];
        return centre + sample_t'(int'($urandom_range(255)) - 128);
    endfunction

    initial begin
        sample_t cx, cy, cz;
        int      idle_plan [4];
        int      stall_plan [4];
        sb = new();
        idle_plan  = '{0, 81, 0, 30};
        stall_plan = '{0, 0, 81, 30};

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // warm-up at the extremes so the first x and y biases sit at the rails
        for (int i = 0; i < gwbr_pkg::WINDOW_DEPTH_DEF; i++) begin
            send_sample(-16'sd32768, 16'sd32767, (i % 2) ? 16'sh5555 : 16'shaaaa,
                        1'(i % 2));
        end
        // largest positive and negative corrected rates, window frozen
        send_sample(16'sd32767, -16'sd32768, 16'sd0, 1'b0);
        send_sample(-16'sd32768, 16'sd32767, -16'sd1, 1'b0);
        for (int i = 0; i < 18; i++) begin
            send_sample(corners[$urandom_range(4)], corners[$urandom_range(4)],
                        corners[$urandom_range(4)], i % 3 != 0);
        end
        drain_results();

        for (int p = 0; p < 4; p++) begin
            tx_idle_pct  = idle_plan[p];
            rx_stall_pct = stall_plan[p];
            cx = '0;
            cy = '0;
            cz = '0;
            for (int i = 0; i < 480; i++) begin
                if (i % 96 == 0) begin
                    cx = sample_t'($urandom);
                    cy = sample_t'($urandom);
                    cz = sample_t'($urandom);
                end
                send_sample(pick_rate(cx), pick_rate(cy), pick_rate(cz),
                            $urandom_range(3) != 0);
            end
            drain_results();
        end

        repeat (8) @(posedge aclk);
        if (sb.pending() != 0)
            $display("%0d expected results never arrived", sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/gwbr_pkg.sv
design/gwbr_axis.sv
design/gyro_window_bias_removal.sv
design/gwbr_checker.sv
bench/gyro_window_bias_removal_test.sv
